// ----- rtl/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// shared defaults, controller states and the command and status groups
// that pass between the counting sort controller and its datapath
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int VALUE_BITS_DEF = 8;
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int FIELD_W        = 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WRITE,
        ST_SCAN_READ,
        ST_SCAN_CHECK,
        ST_SCAN_EMIT
    } cse_state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic load;
        logic incr_write;
        logic scan_init;
        logic read_bin;
        logic cnt_load;
        logic write_zero;
        logic bin_advance;
        logic emit;
        logic batch_clear;
    } cse_cmd_t;

    typedef struct packed {
        logic room;
        logic clr_done;
        logic cnt_zero;
        logic cnt_one;
        logic bin_at_hi;
        logic out_free;
    } cse_sts_t;

endpackage

// ----- rtl/cse_ctrl.sv -----
// ----------------------------------------------------------------------------
// cse_ctrl
// controller: clearing pass, load sequencing and the bin scan that emits
// the sorted words
// ----------------------------------------------------------------------------
module cse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tlast,
    output logic              s_axis_tready,
    input  cse_pkg::cse_sts_t sts,
    output cse_pkg::cse_cmd_t cmd
);
    import cse_pkg::*;

    cse_state_t state_reg;
    cse_state_t state_next;
    logic       last_reg;
    logic       last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    last_next = s_axis_tlast;
                    priority if (sts.room)
                        state_next = ST_LOAD_WRITE;
                    else if (s_axis_tlast)
                        state_next = ST_SCAN_READ;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_LOAD_WRITE:
            begin
                state_next = last_reg ? ST_SCAN_READ : ST_IDLE;
            end
            ST_SCAN_READ:
            begin
                state_next = ST_SCAN_CHECK;
            end
            ST_SCAN_CHECK:
            begin
                priority if (!sts.cnt_zero)
                    state_next = ST_SCAN_EMIT;
                else if (sts.bin_at_hi)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SCAN_CHECK;
            end
            ST_SCAN_EMIT:
            begin
                if (sts.out_free && sts.cnt_one)
                    state_next = sts.bin_at_hi ? ST_IDLE : ST_SCAN_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
                cmd.load      = s_axis_tvalid && sts.room;
                cmd.scan_init = s_axis_tvalid && !sts.room && s_axis_tlast;
            end
            ST_LOAD_WRITE:
            begin
                cmd.incr_write = 1'b1;
                cmd.scan_init  = last_reg;
            end
            ST_SCAN_READ:
            begin
                cmd.read_bin = 1'b1;
            end
            ST_SCAN_CHECK:
            begin
                cmd.cnt_load    = 1'b1;
                cmd.write_zero  = 1'b1;
                cmd.bin_advance = sts.cnt_zero && !sts.bin_at_hi;
                cmd.batch_clear = sts.cnt_zero && sts.bin_at_hi;
            end
            ST_SCAN_EMIT:
            begin
                cmd.emit        = sts.out_free;
                cmd.bin_advance = sts.out_free && sts.cnt_one && !sts.bin_at_hi;
                cmd.batch_clear = sts.out_free && sts.cnt_one && sts.bin_at_hi;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ----- rtl/cse_dp.sv -----
// ----------------------------------------------------------------------------
// cse_dp
// datapath: histogram memory, batch count, min and max tracking, scan
// pointer and the output word register
// ----------------------------------------------------------------------------
module cse_dp #(
    parameter int VALUE_BITS = cse_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = cse_pkg::MAX_ITEMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cse_pkg::FIELD_W-1:0] s_axis_tdata,   // value
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cse_pkg::FIELD_W-1:0] m_axis_tdata,   // value_res
    output logic                        m_axis_tlast,
    input  cse_pkg::cse_cmd_t           cmd,
    output cse_pkg::cse_sts_t           sts
);
    import cse_pkg::*;

    localparam int NUM_BINS = 1 << VALUE_BITS;
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0]      bin_mem [NUM_BINS];
    logic [CNT_W-1:0]      rd_data_reg;

    logic [VALUE_BITS-1:0] clr_reg;
    logic [VALUE_BITS-1:0] clr_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [CNT_W-1:0]      item_count_reg;
    logic [CNT_W-1:0]      item_count_next;
    logic [VALUE_BITS-1:0] min_reg;
    logic [VALUE_BITS-1:0] min_next;
    logic [VALUE_BITS-1:0] max_reg;
    logic [VALUE_BITS-1:0] max_next;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [FIELD_W-1:0]    out_data_reg;
    logic [FIELD_W-1:0]    out_data_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic [VALUE_BITS+FIELD_W-1:0] in_ext;
    logic [VALUE_BITS+FIELD_W-1:0] bin_ext;
    logic [VALUE_BITS-1:0]         in_value;
    logic [VALUE_BITS-1:0]         bin_inc;

    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_addr;
    logic [CNT_W-1:0]      wr_data;
    logic                  rd_en;
    logic [VALUE_BITS-1:0] rd_addr;

    assign in_ext   = {{VALUE_BITS{1'b0}}, s_axis_tdata};
    assign in_value = in_ext[VALUE_BITS-1:0];
    assign bin_ext  = {{FIELD_W{1'b0}}, bin_reg};
    assign bin_inc  = bin_reg + 1'b1;

    // single write port
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = bin_reg;
        wr_data = '0;
        priority if (cmd.clr_step)
        begin
            wr_addr = clr_reg;
        end
        else if (cmd.incr_write)
        begin
            wr_addr = value_reg;
            wr_data = rd_data_reg + 1'b1;
        end
        else if (cmd.write_zero)
        begin
            wr_addr = bin_reg;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // single read port
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = bin_reg;
        priority if (cmd.load)
            rd_addr = in_value;
        else if (cmd.bin_advance)
            rd_addr = bin_inc;
        else if (cmd.read_bin)
            rd_addr = bin_reg;
        else
            rd_en = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            bin_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= bin_mem[rd_addr];
    end

    always_comb
    begin
        clr_next        = cmd.clr_step ? clr_reg + 1'b1 : clr_reg;
        value_next      = cmd.capture ? in_value : value_reg;
        item_count_next = item_count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        if (cmd.load)
        begin
            item_count_next = item_count_reg + 1'b1;
            if (in_value < min_reg)
                min_next = in_value;
            if (in_value > max_reg)
                max_next = in_value;
        end
        if (cmd.batch_clear)
        begin
            item_count_next = '0;
            min_next        = '1;
            max_next        = '0;
        end

        bin_next = bin_reg;
        priority if (cmd.scan_init)
            bin_next = min_next;
        else if (cmd.bin_advance)
            bin_next = bin_inc;
        else
            bin_next = bin_reg;

        cnt_next = cnt_reg;
        priority if (cmd.cnt_load)
            cnt_next = rd_data_reg;
        else if (cmd.emit)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;

        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = bin_ext[FIELD_W-1:0];
            out_last_next  = sts.bin_at_hi && sts.cnt_one;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            item_count_reg <= '0;
            min_reg        <= '1;
            max_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_reg        <= clr_next;
            item_count_reg <= item_count_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        bin_reg      <= bin_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign sts.room      = item_count_reg < CNT_W'(MAX_ITEMS);
    assign sts.clr_done  = clr_reg == {VALUE_BITS{1'b1}};
    assign sts.cnt_zero  = rd_data_reg == '0;
    assign sts.cnt_one   = cnt_reg == CNT_W'(1);
    assign sts.bin_at_hi = bin_reg == max_reg;
    assign sts.out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- rtl/counting_sort_engine.sv -----
// ----------------------------------------------------------------------------
// counting_sort_engine
// load: each accepted word takes a histogram read, then an increment write;
//   s_axis_tready is low during the write
// sort: after the last word, the min bin is read, then each bin from min to max
//   is checked and its words emitted, holding while the output word is pending
// reset: clearing pass over all 2^VALUE_BITS bins, s_axis_tready low meanwhile
// ----------------------------------------------------------------------------
module counting_sort_engine #(
    parameter int VALUE_BITS = cse_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = cse_pkg::MAX_ITEMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cse_pkg::FIELD_W-1:0] s_axis_tdata,   // value
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cse_pkg::FIELD_W-1:0] m_axis_tdata,   // value_res
    output logic                        m_axis_tlast
);
    import cse_pkg::*;

    cse_cmd_t cmd;
    cse_sts_t sts;

    cse_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    cse_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .sts           (sts)
    );

    // never overwrite a word still waiting downstream
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit while output word pending");

    // one write per cycle on the histogram memory
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.incr_write, cmd.write_zero}))
        else $error("histogram write conflict");

    // one read per cycle on the histogram memory
    a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.read_bin, cmd.bin_advance}))
        else $error("histogram read conflict");

    // a check that loads a non-empty bin moves the scan on to emission
    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_load && !sts.cnt_zero |=> !cmd.cnt_load)
        else $error("scan did not move to emission");

endmodule
